/* hdl/aabb_fc_pkg.sv */
// ---------------------------------------------------------------------------
// aabb_fc_pkg
// shared types and constants of the box versus frustum cull pipeline
// ---------------------------------------------------------------------------
package aabb_fc_pkg;

    localparam int ENTRY_W   = 32;
    localparam int ENTRY_CNT = 16;
    localparam int INDEX_W   = 4;
    localparam int NORM_W    = ENTRY_W + 1;
    localparam int PLANE_CNT = 6;
    localparam int AXIS_CNT  = 3;
    localparam int D_SHIFT   = 16;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TEST = 1'b1
    } t_mode;

    // plane in matrix units: normal components and offset, all Q17.16
    typedef struct packed {
        logic [AXIS_CNT-1:0][NORM_W-1:0] n;
        logic [NORM_W-1:0]               d;
    } t_plane;

endpackage

/* hdl/aabb_frustum_cull_test_unit.sv */
// ---------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// culls boxes against the six side planes of a loaded view-projection matrix
// visible result: box register, plane stages a to c, output register
// throughput: one request per cycle while not stalled, load or test; one pipeline stall signal
// reset: synchronous, clears valids, matrix to zero, culling enabled
// ---------------------------------------------------------------------------
module aabb_frustum_cull_test_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_mode,
    input  logic [aabb_fc_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic signed [aabb_fc_pkg::ENTRY_W-1:0] i_entry_value,
    input  logic signed [COORD_WIDTH-1:0]        i_min_x,
    input  logic signed [COORD_WIDTH-1:0]        i_min_y,
    input  logic signed [COORD_WIDTH-1:0]        i_min_z,
    input  logic signed [COORD_WIDTH-1:0]        i_max_x,
    input  logic signed [COORD_WIDTH-1:0]        i_max_y,
    input  logic signed [COORD_WIDTH-1:0]        i_max_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_visible
);

    localparam int NW = aabb_fc_pkg::NORM_W;
    localparam int EW = aabb_fc_pkg::ENTRY_W;
    localparam int PC = aabb_fc_pkg::PLANE_CNT;
    localparam int AX = aabb_fc_pkg::AXIS_CNT;

    logic [aabb_fc_pkg::ENTRY_CNT-1:0][EW-1:0] r_matrix;
    logic                          r_cull_en;

    logic                          r_s1_valid;
    logic                          r_s2_valid;
    logic                          r_s3_valid;
    logic                          r_s4_valid;
    logic                          r_out_valid;
    logic                          r_visible;

    logic signed [COORD_WIDTH-1:0] r_s1_min [AX];
    logic signed [COORD_WIDTH-1:0] r_s1_max [AX];

    logic                          w_adv;
    logic                          w_accept;
    aabb_fc_pkg::t_plane           w_plane [PC];
    logic [PC-1:0]                 w_cull;

    assign w_adv       = !r_out_valid || !i_stall;
    assign o_stall     = !w_adv;
    assign w_accept    = i_valid && w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_visible   = r_visible;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix    <= '0;
            r_cull_en   <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cull_en <= i_cfg_data;
            end
            if (w_accept && (i_mode == aabb_fc_pkg::MODE_LOAD)) begin
                r_matrix[i_entry_index] <= i_entry_value;
            end
            if (w_adv) begin
                r_s1_valid  <= w_accept && (i_mode == aabb_fc_pkg::MODE_TEST);
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_min[0] <= i_min_x;
            r_s1_min[1] <= i_min_y;
            r_s1_min[2] <= i_min_z;
            r_s1_max[0] <= i_max_x;
            r_s1_max[1] <= i_max_y;
            r_s1_max[2] <= i_max_z;
            r_visible   <= !r_cull_en || !(|w_cull);
        end
    end

    // side planes: row four plus or minus rows one to three
    for (genvar k = 0; k < PC; k++) begin : g_plane
        localparam int ROW = k / 2;
        localparam bit NEG = (k % 2) == 1;

        for (genvar c = 0; c < AX; c++) begin : g_axis
            assign w_plane[k].n[c] = NEG
                ? NW'($signed(r_matrix[c*4+3])) - NW'($signed(r_matrix[c*4+ROW]))
                : NW'($signed(r_matrix[c*4+3])) + NW'($signed(r_matrix[c*4+ROW]));
        end
        assign w_plane[k].d = NEG
            ? NW'($signed(r_matrix[15])) - NW'($signed(r_matrix[12+ROW]))
            : NW'($signed(r_matrix[15])) + NW'($signed(r_matrix[12+ROW]));

        aabb_fc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_eval (
            .i_clk     (i_clk),
            .i_adv     (w_adv),
            .i_plane   (w_plane[k]),
            .i_box_min (r_s1_min),
            .i_box_max (r_s1_max),
            .o_cull    (w_cull[k])
        );
    end

endmodule

/* hdl/aabb_fc_plane_eval.sv */
// ---------------------------------------------------------------------------
// aabb_fc_plane_eval
// one frustum plane: positive corner pick, split products, sums and sign
// ---------------------------------------------------------------------------
module aabb_fc_plane_eval #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  aabb_fc_pkg::t_plane           i_plane,
    input  logic signed [COORD_WIDTH-1:0] i_box_min [aabb_fc_pkg::AXIS_CNT],
    input  logic signed [COORD_WIDTH-1:0] i_box_max [aabb_fc_pkg::AXIS_CNT],
    output logic                          o_cull
);

    localparam int NW        = aabb_fc_pkg::NORM_W;
    localparam int AX        = aabb_fc_pkg::AXIS_CNT;
    localparam int LO_W      = (COORD_WIDTH + 1) / 2;
    localparam int HI_W      = COORD_WIDTH - LO_W;
    localparam int LO_PROD_W = NW + LO_W + 1;
    localparam int HI_PROD_W = NW + HI_W;
    localparam int D_W       = NW + aabb_fc_pkg::D_SHIFT;
    localparam int LO_SUM_W  = ((LO_PROD_W > D_W) ? LO_PROD_W : D_W) + 2;
    localparam int HI_SUM_W  = HI_PROD_W + 2;
    localparam int TOT_W     = ((HI_SUM_W + LO_W > LO_SUM_W) ? HI_SUM_W + LO_W : LO_SUM_W) + 1;

    // stage a: normal, offset and split corner
    logic signed [NW-1:0]        r_n  [AX];
    logic signed [NW-1:0]        r_d_a;
    logic signed [HI_W-1:0]      r_ph [AX];
    logic        [LO_W-1:0]      r_pl [AX];
    logic                        r_zero_a;

    // stage b: partial products
    logic signed [HI_PROD_W-1:0] r_hi_prod [AX];
    logic signed [LO_PROD_W-1:0] r_lo_prod [AX];
    logic signed [NW-1:0]        r_d_b;
    logic                        r_zero_b;

    // stage c: partial sums
    logic signed [HI_SUM_W-1:0]  r_hi_sum;
    logic signed [LO_SUM_W-1:0]  r_lo_sum;
    logic                        r_zero_c;

    logic signed [COORD_WIDTH-1:0] w_corner [AX];
    logic signed [TOT_W-1:0]       w_total;

    always_comb begin
        for (int c = 0; c < AX; c++) begin
            w_corner[c] = i_plane.n[c][NW-1] ? i_box_min[c] : i_box_max[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < AX; c++) begin
                r_n[c]  <= $signed(i_plane.n[c]);
                r_ph[c] <= w_corner[c][COORD_WIDTH-1:LO_W];
                r_pl[c] <= w_corner[c][LO_W-1:0];
            end
            r_d_a    <= $signed(i_plane.d);
            r_zero_a <= (i_plane.n == '0);

            for (int c = 0; c < AX; c++) begin
                r_hi_prod[c] <= HI_PROD_W'(r_n[c]) * HI_PROD_W'(r_ph[c]);
                r_lo_prod[c] <= LO_PROD_W'(r_n[c])
                              * LO_PROD_W'($signed({1'b0, r_pl[c]}));
            end
            r_d_b    <= r_d_a;
            r_zero_b <= r_zero_a;

            r_hi_sum <= HI_SUM_W'(r_hi_prod[0]) + HI_SUM_W'(r_hi_prod[1])
                      + HI_SUM_W'(r_hi_prod[2]);
            r_lo_sum <= LO_SUM_W'(r_lo_prod[0]) + LO_SUM_W'(r_lo_prod[1])
                      + LO_SUM_W'(r_lo_prod[2])
                      + (LO_SUM_W'(r_d_b) <<< aabb_fc_pkg::D_SHIFT);
            r_zero_c <= r_zero_b;
        end
    end

    assign w_total = (TOT_W'(r_hi_sum) <<< LO_W) + TOT_W'(r_lo_sum);
    assign o_cull  = !r_zero_c && w_total[TOT_W-1];

endmodule

/* hdl/aabb_fc_checker.sv */
// ---------------------------------------------------------------------------
// aabb_fc_checker
// port-level checks of the cull pipeline, bound to the top level
// ---------------------------------------------------------------------------
module aabb_fc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_visible
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_visible)))
        else $error("stalled result changed");

    // input side only stalls behind a waiting, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back pressure");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // with no result and no request taken, the pipeline drains and no result appears
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !(i_valid && !o_stall)) [*5] |=> !o_valid)
        else $error("result without request");

endmodule

bind aabb_frustum_cull_test_unit aabb_fc_checker u_chk (.*);
